// ----- hw/rtl/bfcm_pkg.sv -----
// Package for the buffer frame clock manager: sizes, codes and command types.
package bfcm_pkg;
  localparam int unsigned Frames = 64;
  localparam int unsigned FrameW = $clog2(Frames);
  localparam int unsigned CountW = FrameW + 1;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned TagW   = 40;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_UNPIN   = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_DISPOSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ALL_PIN   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NOT_PIN   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_LOOK_CHK,
    S_SWEEP,
    S_SWEEP_CHK,
    S_APPLY,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, reset scan counters
    logic look_rd;    // unused; the tag at the scan index is read by default
    logic look_next;  // advance scan index
    logic sweep_rd;   // advance hand, read tag under it
    logic sweep_step; // evaluate swept frame (clear ref bit)
    logic apply;      // commit op and form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic look_match;
    logic look_last;
    logic sweep_take;
    logic sweep_last;
    logic op_read;
    logic op_alloc;
  } sts_t;
endpackage

// ----- hw/rtl/bfcm_ram.sv -----
// Generic single-port RAM with registered read.
module bfcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- hw/rtl/bfcm_datapath.sv -----
// Datapath: frame tags, status bits, pin counts, clock hand and result word.
module bfcm_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfcm_pkg::CfgW-1:0]   cfg_wdata_i,
  input  bfcm_pkg::cmd_t              cmd_i,
  output bfcm_pkg::sts_t              sts_o,
  input  logic [1:0]                  op_i,
  input  logic [7:0]                  file_id_i,
  input  logic [31:0]                 page_no_i,
  input  logic                        dirty_mark_i,
  output logic [5:0]                  frame_o,
  output logic                        hit_o,
  output logic [1:0]                  status_o,
  output logic                        evicted_o,
  output logic                        write_back_o,
  output logic [7:0]                  victim_file_o,
  output logic [31:0]                 victim_page_o
);
  import bfcm_pkg::*;

  logic [CfgW-1:0]   fiu_q;
  logic [CountW-1:0] n_act;
  logic [Frames-1:0] valid_q, ref_q, dirty_q;
  logic [FrameW-1:0] hand_q, hand_d, idx_q, sel;
  logic [CountW:0]   step_q;
  logic [1:0]        op_q;
  logic [7:0]        file_q;
  logic [31:0]       page_q;
  logic              mark_q, found_q, vic_q;
  logic [FrameW-1:0] fidx_q, vidx_q;
  logic              ram_we;
  logic [FrameW-1:0] ram_addr;
  logic [TagW-1:0]   ram_rd;
  logic              pin_we;
  logic [FrameW-1:0] pin_addr;
  logic [7:0]        pin_rd, pin_wd;
  logic [5:0]        frame_d;
  logic              hit_d, evicted_d, wb_d;
  logic [1:0]        status_d;
  logic [7:0]        vfile_d;
  logic [31:0]       vpage_d;

  always_comb begin
    if (fiu_q == '0) n_act = CountW'(1);
    else if (32'(fiu_q) > Frames) n_act = CountW'(Frames);
    else n_act = CountW'(fiu_q);
  end

  always_comb begin
    if (CountW'(hand_q) + CountW'(1) >= n_act) hand_d = '0;
    else hand_d = hand_q + FrameW'(1);
  end

  assign ram_we   = cmd_i.apply && vic_q;
  assign ram_addr = cmd_i.sweep_rd ? hand_d : (ram_we ? vidx_q : idx_q);

  bfcm_ram #(.Width(TagW), .Depth(Frames)) u_tags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({file_q, page_q}),
    .rdata_o (ram_rd)
  );

  // pin counts are read only for valid frames, which were always written first
  assign pin_we   = cmd_i.apply && (found_q || vic_q);
  assign pin_addr = cmd_i.apply ? (vic_q ? vidx_q : fidx_q) : ram_addr;

  bfcm_ram #(.Width(8), .Depth(Frames)) u_pins (
    .clk_i   (clk_i),
    .we_i    (pin_we),
    .addr_i  (pin_addr),
    .wdata_i (pin_wd),
    .rdata_o (pin_rd)
  );

  // idx_q tracks the frame whose tag is in ram_rd
  assign sel = idx_q;
  assign sts_o.look_match = valid_q[sel] && ram_rd == {file_q, page_q};
  assign sts_o.look_last  = CountW'(idx_q) + CountW'(1) >= n_act;
  assign sts_o.sweep_take = !valid_q[hand_q] || (!ref_q[hand_q] && pin_rd == 8'd0);
  assign sts_o.sweep_last = step_q + (CountW+1)'(1) >= {n_act, 1'b0};
  assign sts_o.op_read    = op_q == OP_READ;
  assign sts_o.op_alloc   = op_q == OP_ALLOC;

  // result word and new pin count for the commit step
  always_comb begin
    frame_d   = '0;
    hit_d     = 1'b0;
    status_d  = ST_OK;
    evicted_d = 1'b0;
    wb_d      = 1'b0;
    vfile_d   = '0;
    vpage_d   = '0;
    pin_wd    = pin_rd;
    if (op_q == OP_READ && found_q) begin
      if (pin_rd != 8'hff) pin_wd = pin_rd + 8'd1;
      frame_d = 6'(fidx_q);
      hit_d   = 1'b1;
    end else if (op_q == OP_READ || op_q == OP_ALLOC) begin
      if (!vic_q) begin
        status_d = ST_ALL_PIN;
      end else begin
        if (valid_q[vidx_q]) begin
          evicted_d = 1'b1;
          wb_d      = dirty_q[vidx_q];
          vfile_d   = ram_rd[TagW-1:32];
          vpage_d   = ram_rd[31:0];
        end
        pin_wd  = 8'd1;
        frame_d = 6'(vidx_q);
      end
    end else if (!found_q) begin
      status_d = ST_NOT_FOUND;
    end else if (op_q == OP_UNPIN) begin
      frame_d = 6'(fidx_q);
      if (pin_rd == 8'd0) status_d = ST_NOT_PIN;
      else pin_wd = pin_rd - 8'd1;
    end else begin
      frame_d = 6'(fidx_q);
      pin_wd  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q   <= CfgW'(64);
      hand_q  <= FrameW'(Frames - 1);
      valid_q <= '0;
      ref_q   <= '0;
      dirty_q <= '0;
      found_q <= 1'b0;
      vic_q   <= 1'b0;
      idx_q   <= '0;
      step_q  <= '0;
      op_q    <= '0;
      file_q  <= '0;
      page_q  <= '0;
      mark_q  <= 1'b0;
      fidx_q  <= '0;
      vidx_q  <= '0;
      frame_o       <= '0;
      hit_o         <= 1'b0;
      status_o      <= ST_OK;
      evicted_o     <= 1'b0;
      write_back_o  <= 1'b0;
      victim_file_o <= '0;
      victim_page_o <= '0;
    end else begin
      if (cfg_we_i) begin
        fiu_q  <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        op_q    <= op_i;
        file_q  <= file_id_i;
        page_q  <= page_no_i;
        mark_q  <= dirty_mark_i;
        idx_q   <= '0;
        step_q  <= '0;
        found_q <= 1'b0;
        vic_q   <= 1'b0;
      end
      if (cmd_i.look_next) begin
        if (sts_o.look_match && !found_q) begin
          found_q <= 1'b1;
          fidx_q  <= idx_q;
        end
        idx_q <= idx_q + FrameW'(1);
      end
      if (cmd_i.sweep_rd) begin
        hand_q <= hand_d;
        idx_q  <= hand_d;
      end
      if (cmd_i.sweep_step) begin
        step_q <= step_q + (CountW+1)'(1);
        if (sts_o.sweep_take) begin
          vic_q  <= 1'b1;
          vidx_q <= hand_q;
        end else if (ref_q[hand_q]) begin
          ref_q[hand_q] <= 1'b0;
        end
      end
      if (cmd_i.apply) begin
        frame_o       <= frame_d;
        hit_o         <= hit_d;
        status_o      <= status_d;
        evicted_o     <= evicted_d;
        write_back_o  <= wb_d;
        victim_file_o <= vfile_d;
        victim_page_o <= vpage_d;
        if (op_q == OP_READ && found_q) begin
          ref_q[fidx_q] <= 1'b1;
        end else if ((op_q == OP_READ || op_q == OP_ALLOC) && vic_q) begin
          valid_q[vidx_q] <= 1'b1;
          ref_q[vidx_q]   <= 1'b1;
          dirty_q[vidx_q] <= 1'b0;
        end else if (found_q && op_q == OP_UNPIN) begin
          if (mark_q && pin_rd != 8'd0) dirty_q[fidx_q] <= 1'b1;
        end else if (found_q && op_q == OP_DISPOSE) begin
          valid_q[fidx_q] <= 1'b0;
          ref_q[fidx_q]   <= 1'b0;
          dirty_q[fidx_q] <= 1'b0;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/bfcm_ctrl.sv -----
// Controller: sequences lookup scan, clock sweep, commit and result handoff.
module bfcm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bfcm_pkg::sts_t sts_i,
  output bfcm_pkg::cmd_t cmd_o
);
  import bfcm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        // alloc skips the lookup
        if (sts_i.op_alloc) begin
          cmd_o.sweep_rd = 1'b1;
          state_d = S_SWEEP_CHK;
        end else begin
          state_d = S_LOOK_CHK;
        end
      end
      S_LOOK_CHK: begin
        cmd_o.look_next = 1'b1;
        if (sts_i.look_match || sts_i.look_last) begin
          if (sts_i.op_read && !sts_i.look_match) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_APPLY;
          end
        end else begin
          state_d = S_LOOK;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        state_d = S_SWEEP_CHK;
      end
      S_SWEEP_CHK: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_take || sts_i.sweep_last) state_d = S_APPLY;
        else state_d = S_SWEEP;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/buffer_frame_clock_manager.sv -----
// Top level of the buffer frame clock manager.
// Each frame scanned in lookup (up to frames_in_use) takes a read step and a check step,
// as does each frame swept (up to twice frames_in_use), before the commit and result steps.
// One word at a time; the single-port tag RAM with registered read sets the read-then-check step.
// Reset clears all frame status bits, sets frames_in_use to 64 and parks the hand
// on the last frame; frame tags and pin counts live in RAM and are not cleared.
module buffer_frame_clock_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  file_id_i,
  input  logic [31:0] page_no_i,
  input  logic        dirty_mark_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  frame_o,
  output logic        hit_o,
  output logic [1:0]  status_o,
  output logic        evicted_o,
  output logic        write_back_o,
  output logic [7:0]  victim_file_o,
  output logic [31:0] victim_page_o
);
  import bfcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfcm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  bfcm_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .cmd_i(cmd), .sts_o(sts),
    .op_i, .file_id_i, .page_no_i, .dirty_mark_i, .frame_o, .hit_o, .status_o,
    .evicted_o, .write_back_o, .victim_file_o, .victim_page_o
  );
endmodule

// ----- hw/rtl/bfcm_checker.sv -----
// Port-level checker for the buffer frame clock manager, bound to the top level.
module bfcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [1:0]  status_o,
  input logic        evicted_o,
  input logic [5:0]  frame_o
);
  import bfcm_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_o))
    else $error("result dropped");
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == ST_OK && !evicted_o)
    else $error("hit with bad status");
  a_fail_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ALL_PIN || status_o == ST_NOT_FOUND) |-> frame_o == 6'd0)
    else $error("frame set on failure");
endmodule

bind buffer_frame_clock_manager bfcm_checker u_bfcm_checker (.*);

// ----- bench/tb_top.sv -----
// Testbench for the buffer frame clock manager: directed table, random traffic, scoreboard.
module tb_top;
  import bfcm_pkg::*;

  localparam int NumFrames = 64;
  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  file_id_i = '0;
  logic [31:0] page_no_i = '0;
  logic        dirty_mark_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  frame_o;
  logic        hit_o;
  logic [1:0]  status_o;
  logic        evicted_o;
  logic        write_back_o;
  logic [7:0]  victim_file_o;
  logic [31:0] victim_page_o;

  always #6 clk_i = ~clk_i;

  buffer_frame_clock_manager dut (.*);

  typedef struct packed {
    logic [5:0]  frame;
    logic        hit;
    logic [1:0]  status;
    logic        evicted;
    logic        wb;
    logic [7:0]  vfile;
    logic [31:0] vpage;
  } lookup_res_t;

  typedef struct {
    op_e         op;
    logic [7:0]  file;
    logic [31:0] page;
    logic        mark;
    logic        typed;   // expected value given below
    lookup_res_t res;
  } req_row_t;

  // predictor state
  logic [6:0]  pool_size;
  logic        f_valid[NumFrames];
  logic        f_ref[NumFrames];
  logic        f_dirty[NumFrames];
  logic [7:0]  f_pin[NumFrames];
  logic [7:0]  f_file[NumFrames];
  logic [31:0] f_page[NumFrames];
  int unsigned hand;

  lookup_res_t pending_res[$];
  int errors = 0;
  int n_words = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_evict = 0;
  int n_allpin = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  int quiet_cycles = 0;

  function automatic int unsigned pool_frames();
    if (pool_size == 0) return 1;
    if (pool_size > NumFrames) return NumFrames;
    return pool_size;
  endfunction

  function automatic int find_page(logic [7:0] file, logic [31:0] page);
    for (int i = 0; i < pool_frames(); i++)
      if (f_valid[i] && f_file[i] == file && f_page[i] == page) return i;
    return -1;
  endfunction

  function automatic void reset_pool();
    pool_size = 7'd64;
    for (int i = 0; i < NumFrames; i++) begin
      f_valid[i] = 1'b0; f_ref[i] = 1'b0; f_dirty[i] = 1'b0; f_pin[i] = '0;
      f_file[i] = '0; f_page[i] = '0;
    end
    hand = pool_frames() - 1;
  endfunction

  function automatic lookup_res_t serve_request(op_e op, logic [7:0] file,
                                                logic [31:0] page, logic mark);
    lookup_res_t r;
    int id;
    int v;
    int unsigned n;
    r = '0;
    id = find_page(file, page);
    n = pool_frames();
    if (op == OP_READ && id >= 0) begin
      if (f_pin[id] != 8'hff) f_pin[id]++;
      f_ref[id] = 1'b1;
      r.frame = 6'(id);
      r.hit = 1'b1;
    end else if (op == OP_READ || op == OP_ALLOC) begin
      v = -1;
      for (int s = 0; s < 2 * n; s++) begin
        hand = (hand + 1 >= n) ? 0 : hand + 1;
        if (!f_valid[hand]) begin v = int'(hand); break; end
        if (f_ref[hand]) begin f_ref[hand] = 1'b0; continue; end
        if (f_pin[hand] != 0) continue;
        v = int'(hand);
        break;
      end
      if (v < 0) begin
        r.status = ST_ALL_PIN;
      end else begin
        if (f_valid[v]) begin
          r.evicted = 1'b1; r.wb = f_dirty[v]; r.vfile = f_file[v]; r.vpage = f_page[v];
        end
        f_valid[v] = 1'b1; f_ref[v] = 1'b1; f_dirty[v] = 1'b0; f_pin[v] = 8'd1;
        f_file[v] = file; f_page[v] = page;
        r.frame = 6'(v);
      end
    end else if (op == OP_UNPIN) begin
      if (id < 0) r.status = ST_NOT_FOUND;
      else begin
        r.frame = 6'(id);
        if (f_pin[id] == 0) r.status = ST_NOT_PIN;
        else begin
          if (mark) f_dirty[id] = 1'b1;
          f_pin[id]--;
        end
      end
    end else begin
      if (id < 0) r.status = ST_NOT_FOUND;
      else begin
        r.frame = 6'(id);
        f_valid[id] = 1'b0; f_ref[id] = 1'b0; f_dirty[id] = 1'b0; f_pin[id] = '0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // drive one word; hold valid and payload until accepted
  task automatic send_word(op_e op, logic [7:0] file, logic [31:0] page, logic mark,
                           logic typed, lookup_res_t want);
    lookup_res_t r;
    if ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_in_pct) @(posedge clk_i);
    end
    r = serve_request(op, file, page, mark);
    if (typed && r !== want) begin
      report_mismatch("typed row", 32'(n_words), 32'(r.status));
    end
    pending_res.push_back(r);
    in_valid_i <= 1'b1;
    op_i <= op; file_id_i <= file; page_no_i <= page; dirty_mark_i <= mark;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_words++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_pool(logic [6:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_size = value;
  endtask

  // receiver side and scoreboard
  always @(posedge clk_i) begin
    lookup_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_res.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = pending_res.pop_front();
          n_results++;
          if (want.hit) n_hits++;
          if (want.evicted) n_evict++;
          if (want.status == ST_ALL_PIN) n_allpin++;
          if (frame_o !== want.frame) report_mismatch("frame", 32'(frame_o), 32'(want.frame));
          if (hit_o !== want.hit) report_mismatch("hit", 32'(hit_o), 32'(want.hit));
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", 32'(evicted_o), 32'(want.evicted));
          if (write_back_o !== want.wb)
            report_mismatch("write_back", 32'(write_back_o), 32'(want.wb));
          if (victim_file_o !== want.vfile)
            report_mismatch("victim_file", 32'(victim_file_o), 32'(want.vfile));
          if (victim_page_o !== want.vpage)
            report_mismatch("victim_page", victim_page_o, want.vpage);
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_out_pct);
      quiet_cycles <= ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) ? 0
                      : quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results pending", pending_res.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // random word biased toward a small working set so hits, unpins and disposes land
  task automatic random_word();
    op_e op;
    logic [7:0] file;
    logic [31:0] page;
    int k;
    k = $urandom_range(99);
    op = (k < 35) ? OP_READ : (k < 65) ? OP_UNPIN : (k < 85) ? OP_ALLOC : OP_DISPOSE;
    if ($urandom_range(9) == 0) begin
      file = 8'($urandom); page = $urandom;
    end else begin
      file = $urandom_range(3) == 0 ? 8'hff : 8'($urandom_range(3));
      page = $urandom_range(3) == 0 ? 32'($urandom_range(15)) | 32'hfffffff0
             : 32'($urandom_range(23));
    end
    send_word(op, file, page, 1'($urandom_range(1)), 1'b0, '0);
  endtask

  req_row_t rows[$];

  initial begin
    lookup_res_t none;
    int phase_words;
    none = '0;
    reset_pool();
    // directed table; typed rows follow from reset state
    rows = '{
      '{OP_UNPIN,   8'h00, 32'h0,        1'b0, 1'b1, '{0, 0, ST_NOT_FOUND, 0, 0, 0, 0}},
      '{OP_DISPOSE, 8'hff, 32'hffffffff, 1'b0, 1'b1, '{0, 0, ST_NOT_FOUND, 0, 0, 0, 0}},
      '{OP_READ,    8'hff, 32'hffffffff, 1'b0, 1'b1, '{0, 0, ST_OK, 0, 0, 0, 0}},
      '{OP_READ,    8'hff, 32'hffffffff, 1'b0, 1'b1, '{0, 1, ST_OK, 0, 0, 0, 0}},
      '{OP_ALLOC,   8'h00, 32'h0,        1'b0, 1'b1, '{1, 0, ST_OK, 0, 0, 0, 0}},
      '{OP_ALLOC,   8'h00, 32'h0,        1'b0, 1'b0, none},
      '{OP_UNPIN,   8'h00, 32'h0,        1'b1, 1'b1, '{1, 0, ST_OK, 0, 0, 0, 0}},
      '{OP_UNPIN,   8'h00, 32'h0,        1'b0, 1'b1, '{1, 0, ST_NOT_PIN, 0, 0, 0, 0}},
      '{OP_UNPIN,   8'hff, 32'hffffffff, 1'b1, 1'b0, none},
      '{OP_UNPIN,   8'hff, 32'hffffffff, 1'b0, 1'b0, none},
      '{OP_DISPOSE, 8'h00, 32'h0,        1'b0, 1'b0, none},
      '{OP_DISPOSE, 8'h00, 32'h0,        1'b0, 1'b0, none},
      '{OP_READ,    8'h5a, 32'ha5a5a5a5, 1'b0, 1'b0, none},
      '{OP_UNPIN,   8'h5a, 32'ha5a5a5a5, 1'b1, 1'b0, none}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      send_word(rows[i].op, rows[i].file, rows[i].page, rows[i].mark,
                rows[i].typed, rows[i].res);

    // tiny pool: fill, pin, saturate the pin count, then all-pinned misses
    set_pool(7'd2);
    send_word(OP_ALLOC, 8'h01, 32'h10, 1'b0, 1'b0, none);
    send_word(OP_ALLOC, 8'h01, 32'h11, 1'b0, 1'b0, none);
    repeat (260) send_word(OP_READ, 8'h01, 32'h10, 1'b0, 1'b0, none);
    send_word(OP_ALLOC, 8'h02, 32'h20, 1'b0, 1'b0, none);
    send_word(OP_READ, 8'h02, 32'h21, 1'b0, 1'b0, none);
    // dirty victim gets written back
    send_word(OP_UNPIN, 8'h01, 32'h11, 1'b1, 1'b0, none);
    send_word(OP_ALLOC, 8'h03, 32'h30, 1'b0, 1'b0, none);
    send_word(OP_ALLOC, 8'h03, 32'h31, 1'b0, 1'b0, none);
    // zero acts as one frame, oversize as the full table
    set_pool(7'd0);
    repeat (6) random_word();
    set_pool(7'd127);
    repeat (6) random_word();

    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct = (ph == 0) ? 15 : (ph == 1) ? 71 : 0;
      idle_out_pct = (ph == 0) ? 71 : (ph == 1) ? 15 : 0;
      set_pool(ph == 0 ? 7'd4 : ph == 1 ? 7'd64 : 7'($urandom_range(1, 12)));
      phase_words = (ph == 2) ? 150 : 600;
      for (int i = 0; i < phase_words; i++) begin
        // hold the sender until every result is back
        if (i == phase_words / 2) begin
          in_valid_i <= 1'b0;
          while (pending_res.size() != 0) @(posedge clk_i);
        end
        random_word();
      end
    end
    idle_out_pct = 0;
    drain_results();
    $display("%0d words sent, %0d results: %0d hits, %0d evictions, %0d all-pinned",
             n_words, n_results, n_hits, n_evict, n_allpin);
    $display("pool sizes 0, 2, 4, 64, 127 and one random size up to 12 exercised");
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
